### hw/rtl/plint_pkg.sv
// Shared types and constants for the piecewise linear interpolator.
package plint_pkg;

  localparam int MAX_NODES = 64;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QFILL_W   = $clog2(QDEPTH + 1);
  localparam int DIV_STEPS = 33;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Command codes on the input word
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_RANGE = 3'd1;
  localparam logic [2:0] ST_DUP   = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;
  localparam logic [2:0] ST_BAD   = 3'd5;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } plint_op_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] coord;
    logic signed [31:0] node_value;
  } plint_cmd_t;

  typedef struct packed {
    logic signed [31:0] interp_value;
    logic [2:0]         status;
  } plint_res_t;

  // Classified word passed from front to back
  typedef struct packed {
    plint_op_t          op;
    logic signed [31:0] coord;
    logic signed [31:0] node_value;
  } plint_qword_t;

endpackage

### hw/rtl/plint_ram.sv
// Generic single-write, single-read RAM with registered read data.
module plint_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/plint_front.sv
// Front end: accepts command words, classifies them, and queues them for the back end.
module plint_front import plint_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cmd_valid,
  output logic         cmd_stall,
  input  plint_cmd_t   cmd_word,
  output logic         q_valid,
  input  logic         q_pop,
  output plint_qword_t q_word
);

  plint_qword_t         entries [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr;
  logic [QPTR_W-1:0]    rd_ptr;
  logic [QFILL_W-1:0]   fill;
  logic                 push;
  logic                 pop;
  plint_op_t            op_class;

  // Decode the command code
  always_comb begin
    unique case (cmd_word.command)
      CMD_CLEAR: op_class = OP_CLEAR;
      CMD_ADD:   op_class = OP_ADD;
      CMD_QUERY: op_class = OP_QUERY;
      default:   op_class = OP_NOP;
    endcase
  end

  assign cmd_stall = (fill == QFILL_W'(QDEPTH));
  assign push      = cmd_valid && !cmd_stall;
  assign q_valid   = (fill != '0);
  assign pop       = q_pop && q_valid;
  assign q_word    = entries[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{op: op_class, coord: cmd_word.coord,
                           node_value: cmd_word.node_value};
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/plint_div.sv
// Interpolation datapath: slope product, restoring divider, offset and saturation.
module plint_div import plint_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] qx,
  input  logic signed [31:0] x0,
  input  logic signed [31:0] x1,
  input  logic signed [31:0] y0,
  input  logic signed [31:0] y1,
  output logic               done,
  output logic signed [31:0] value
);

  typedef enum logic [4:0] {
    D_IDLE = 5'b00001,
    D_MUL  = 5'b00010,
    D_ADD  = 5'b00100,
    D_DIV  = 5'b01000,
    D_FIN  = 5'b10000
  } dstate_t;

  dstate_t             dst;
  logic [32:0]         mag;
  logic                neg;
  logic [31:0]         t;
  logic [31:0]         dx;
  logic signed [31:0]  base;
  logic [63:0]         prod;
  logic [31:0]         rem;
  logic [32:0]         sh;
  logic [STEP_W-1:0]   steps;

  logic signed [32:0]  dy;
  logic [64:0]         p65;
  logic [32:0]         part;
  logic                ge;
  logic [32:0]         trial;
  logic [32:0]         q;
  logic signed [33:0]  sum;

  assign dy    = {y1[31], y1} - {y0[31], y0};
  assign p65   = {1'b0, prod} + (mag[32] ? {1'b0, t, 32'd0} : 65'd0);
  assign part  = {rem, sh[32]};
  assign ge    = (part >= {1'b0, dx});
  assign trial = part - {1'b0, dx};
  assign q     = (dx == '0) ? '0 : sh;
  assign sum   = neg ? ({{2{base[31]}}, base} - {1'b0, q})
                     : ({{2{base[31]}}, base} + {1'b0, q});

  // Saturate to 32 bits
  always_comb begin
    if (sum > 34'sh0_7FFF_FFFF) begin
      value = 32'sh7FFF_FFFF;
    end else if (sum < -34'sh0_8000_0000) begin
      value = 32'sh8000_0000;
    end else begin
      value = sum[31:0];
    end
  end

  assign done = (dst == D_FIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      dst <= D_IDLE;
    end else begin
      unique case (dst)
        D_IDLE: begin
          if (start) begin
            neg  <= dy[32];
            mag  <= dy[32] ? 33'(-dy) : 33'(dy);
            t    <= 32'(qx - x0);
            dx   <= 32'(x1 - x0);
            base <= y0;
            dst  <= D_MUL;
          end
        end
        D_MUL: begin
          prod <= mag[31:0] * t;
          dst  <= D_ADD;
        end
        D_ADD: begin
          rem   <= p65[64:33];
          sh    <= p65[32:0];
          steps <= '0;
          dst   <= D_DIV;
        end
        // One quotient bit per cycle
        D_DIV: begin
          rem   <= ge ? trial[31:0] : part[31:0];
          sh    <= {sh[31:0], ge};
          steps <= steps + 1'b1;
          if (steps == STEP_W'(DIV_STEPS - 1)) begin
            dst <= D_FIN;
          end
        end
        D_FIN: begin
          dst <= D_IDLE;
        end
        default: dst <= D_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/plint_back.sv
// Back end: node table sequencer for clear, sorted insert and point query.
module plint_back import plint_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  output logic         q_pop,
  input  plint_qword_t q_word,
  output logic         res_valid,
  input  logic         res_stall,
  output plint_res_t   res_word
);

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_DUP_RD  = 18'h00002,
    S_DUP_CHK = 18'h00004,
    S_SH_RD   = 18'h00008,
    S_SH_CHK  = 18'h00010,
    S_SH_INS  = 18'h00020,
    S_LO_RD   = 18'h00040,
    S_LO_CHK  = 18'h00080,
    S_HI_RD   = 18'h00100,
    S_HI_CHK  = 18'h00200,
    S_SRCH    = 18'h00400,
    S_MID_RD  = 18'h00800,
    S_MID_CHK = 18'h01000,
    S_A_RD    = 18'h02000,
    S_A_CHK   = 18'h04000,
    S_B_RD    = 18'h08000,
    S_B_CHK   = 18'h10000,
    S_DIV     = 18'h20000
  } bstate_t;

  bstate_t            state;
  logic [CNT_W-1:0]   node_count;
  logic               table_bad;
  logic signed [31:0] qx;
  logic signed [31:0] qy;
  logic [IDX_W-1:0]   ptr;
  logic [IDX_W-1:0]   pos;
  logic [IDX_W-1:0]   lo;
  logic [IDX_W-1:0]   hi;
  logic signed [31:0] ax;
  logic signed [31:0] ay;
  logic signed [31:0] bx;
  logic signed [31:0] by;

  logic               we;
  logic [31:0]        wx;
  logic [31:0]        wy;
  logic [31:0]        rx;
  logic [31:0]        ry;
  logic signed [31:0] xr;
  logic signed [31:0] yr;
  logic [CNT_W-1:0]   cnt_m1;
  logic [IDX_W:0]     mid_sum;
  logic               div_start;
  logic               div_done;
  logic signed [31:0] div_value;

  assign xr      = rx;
  assign yr      = ry;
  assign cnt_m1  = node_count - CNT_W'(1);
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign q_pop   = (state == S_IDLE) && q_valid && !res_valid;
  // Both end nodes are registered by now; the divider ignores start while busy
  assign div_start = (state == S_DIV);

  // Table write port: shift during insert, then the new node
  always_comb begin
    we = 1'b0;
    wx = xr;
    wy = yr;
    if (state == S_SH_CHK && xr > qx) begin
      we = 1'b1;
    end else if (state == S_SH_INS) begin
      we = 1'b1;
      wx = qx;
      wy = qy;
    end
  end

  plint_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_xs (
    .clk(clk), .we(we), .waddr(pos), .wdata(wx), .raddr(ptr), .rdata(rx)
  );

  plint_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_ys (
    .clk(clk), .we(we), .waddr(pos), .wdata(wy), .raddr(ptr), .rdata(ry)
  );

  plint_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .qx(qx), .x0(ax), .x1(bx),
    .y0(ay), .y1(by), .done(div_done), .value(div_value)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= '0;
      table_bad  <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            qx <= q_word.coord;
            qy <= q_word.node_value;
            unique case (q_word.op)
              OP_CLEAR: begin
                node_count <= '0;
                table_bad  <= 1'b0;
                res_valid  <= 1'b1;
                res_word   <= '{interp_value: '0, status: ST_OK};
              end
              OP_ADD: begin
                if (node_count >= CNT_W'(MAX_NODES)) begin
                  res_valid <= 1'b1;
                  res_word  <= '{interp_value: '0, status: ST_FULL};
                end else if (node_count == '0) begin
                  pos   <= '0;
                  state <= S_SH_INS;
                end else begin
                  ptr   <= '0;
                  state <= S_DUP_RD;
                end
              end
              OP_QUERY: begin
                if (table_bad) begin
                  res_valid <= 1'b1;
                  res_word  <= '{interp_value: '0, status: ST_BAD};
                end else if (node_count == '0) begin
                  res_valid <= 1'b1;
                  res_word  <= '{interp_value: '0, status: ST_EMPTY};
                end else begin
                  ptr   <= '0;
                  state <= S_LO_RD;
                end
              end
              default: begin
                res_valid <= 1'b1;
                res_word  <= '{interp_value: '0, status: ST_OK};
              end
            endcase
          end
        end
        S_DUP_RD: state <= S_DUP_CHK;
        // Linear duplicate scan
        S_DUP_CHK: begin
          if (xr == qx) begin
            table_bad <= 1'b1;
            res_valid <= 1'b1;
            res_word  <= '{interp_value: '0, status: ST_DUP};
            state     <= S_IDLE;
          end else if (ptr == cnt_m1[IDX_W-1:0]) begin
            pos   <= node_count[IDX_W-1:0];
            state <= S_SH_RD;
          end else begin
            ptr   <= ptr + 1'b1;
            state <= S_DUP_RD;
          end
        end
        S_SH_RD: state <= S_SH_CHK;
        // Move larger nodes up one place
        S_SH_CHK: begin
          if (xr > qx) begin
            pos <= ptr;
            if (ptr == '0) begin
              state <= S_SH_INS;
            end else begin
              ptr   <= ptr - 1'b1;
              state <= S_SH_RD;
            end
          end else begin
            state <= S_SH_INS;
          end
        end
        S_SH_INS: begin
          node_count <= node_count + 1'b1;
          res_valid  <= 1'b1;
          res_word   <= '{interp_value: '0, status: ST_OK};
          state      <= S_IDLE;
        end
        S_LO_RD: state <= S_LO_CHK;
        S_LO_CHK: begin
          if (qx < xr) begin
            res_valid <= 1'b1;
            res_word  <= '{interp_value: '0, status: ST_RANGE};
            state     <= S_IDLE;
          end else begin
            ptr   <= cnt_m1[IDX_W-1:0];
            state <= S_HI_RD;
          end
        end
        S_HI_RD: state <= S_HI_CHK;
        S_HI_CHK: begin
          if (qx > xr) begin
            res_valid <= 1'b1;
            res_word  <= '{interp_value: '0, status: ST_RANGE};
            state     <= S_IDLE;
          end else if (qx == xr) begin
            res_valid <= 1'b1;
            res_word  <= '{interp_value: yr, status: ST_OK};
            state     <= S_IDLE;
          end else begin
            lo    <= IDX_W'(1);
            hi    <= cnt_m1[IDX_W-1:0];
            state <= S_SRCH;
          end
        end
        // Binary search for the first node above the query
        S_SRCH: begin
          if (lo < hi) begin
            ptr   <= mid_sum[IDX_W:1];
            state <= S_MID_RD;
          end else begin
            ptr   <= hi - 1'b1;
            state <= S_A_RD;
          end
        end
        S_MID_RD: state <= S_MID_CHK;
        S_MID_CHK: begin
          if (xr > qx) begin
            hi <= ptr;
          end else begin
            lo <= ptr + 1'b1;
          end
          state <= S_SRCH;
        end
        S_A_RD: state <= S_A_CHK;
        S_A_CHK: begin
          ax    <= xr;
          ay    <= yr;
          ptr   <= hi;
          state <= S_B_RD;
        end
        S_B_RD: state <= S_B_CHK;
        S_B_CHK: begin
          bx    <= xr;
          by    <= yr;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_valid <= 1'b1;
            res_word  <= '{interp_value: div_value, status: ST_OK};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    node_count <= CNT_W'(MAX_NODES))
    else $error("node count above table size");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    node_count != $past(node_count) |->
      (node_count == $past(node_count) + 1'b1 || node_count == '0))
    else $error("node count moved by more than one");

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> state == S_IDLE)
    else $error("result issued while sequencer busy");

  a_write_insert: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_SH_CHK || state == S_SH_INS))
    else $error("table write outside insert");
`endif

endmodule

### hw/rtl/piecewise_linear_interpolator.sv
// Top level of the piecewise linear interpolator: front queue plus table back end.
//
//   channel  | handshake            | word
//   ---------+----------------------+------------------------------------------
//   cmd      | cmd_valid/cmd_stall  | command, coord, node_value
//   res      | res_valid/res_stall  | interp_value, status
//
// Steps: clear and no-op answer straight from idle; add runs a linear duplicate scan over
// the nodes held, then shifts each larger node up one place; query runs the end lookups and a
// binary search, then the multiply/divide unit (33 quotient bits, one a cycle).
// One word at a time in the back end; the two-word front queue keeps accepting.
// Reset (rst, synchronous) empties the table and the queue; no clearing pass.
// A stalled result holds the back end; the queue stalls cmd only when full.
module piecewise_linear_interpolator import plint_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  plint_cmd_t cmd_word,
  output logic       res_valid,
  input  logic       res_stall,
  output plint_res_t res_word
);

  logic         q_valid;
  logic         q_pop;
  plint_qword_t q_word;

  plint_front u_front (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .cmd_word(cmd_word), .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word)
  );

  plint_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word),
    .res_valid(res_valid), .res_stall(res_stall), .res_word(res_word)
  );

endmodule
